// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the parser rtl
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/acfp_pkg.sv =====
// shared types and constants for the ascii can frame parser
// no dependencies
`default_nettype none

package acfp_pkg;

  localparam int unsigned MAX_CMD_BYTES = 8;
  localparam int unsigned BAUD_MAX_LEN  = 3;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned DIGIT_W       = 5;

  localparam logic [7:0] CH_STD_DATA = 8'h74;  // t
  localparam logic [7:0] CH_STD_RTR  = 8'h72;  // r
  localparam logic [7:0] CH_EXT_DATA = 8'h54;  // T
  localparam logic [7:0] CH_EXT_RTR  = 8'h52;  // R
  localparam logic [7:0] CH_DEV_CMD  = 8'h44;  // D
  localparam logic [7:0] CH_SER_CMD  = 8'h63;  // c
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_EIGHT    = 8'h38;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_F     = 8'h66;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_F     = 8'h46;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_DEVICE = 2'd1,
    KIND_SERIAL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_BAUD = 2'd2
  } status_t;

  // classified character
  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
    logic       dlc_ok;
    logic       frame_start;
    logic       ext;
    logic       remote;
    logic       cmd_start;
    logic       serial;
  } tok_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acfp_front.sv =====
// front end: classifies each accepted character into a token for the queue
// depends on acfp_pkg
`default_nettype none

module acfp_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     char_in,
  input  wire acfp_pkg::q_stat_t q_stat,
  output logic                push,
  output acfp_pkg::tok_t      tok
);
  import acfp_pkg::*;

  logic is_dec, is_lo, is_up;

  always_comb begin
    is_dec = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    is_lo  = (char_in >= CH_LO_A) && (char_in <= CH_LO_F);
    is_up  = (char_in >= CH_UP_A) && (char_in <= CH_UP_F);
    tok.is_hex      = is_dec || is_lo || is_up;
    tok.nib         = is_dec ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);
    tok.dlc_ok      = (char_in >= CH_ZERO) && (char_in <= CH_EIGHT);
    tok.frame_start = (char_in == CH_STD_DATA) || (char_in == CH_STD_RTR) ||
                      (char_in == CH_EXT_DATA) || (char_in == CH_EXT_RTR);
    tok.ext         = (char_in == CH_EXT_DATA) || (char_in == CH_EXT_RTR);
    tok.remote      = (char_in == CH_STD_RTR) || (char_in == CH_EXT_RTR);
    tok.cmd_start   = (char_in == CH_DEV_CMD) || (char_in == CH_SER_CMD);
    tok.serial      = (char_in == CH_SER_CMD);
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

`default_nettype wire

// ===== hw/rtl/acfp_queue.sv =====
// two-entry token queue between the classifier and the parser
// depends on acfp_pkg
`default_nettype none

module acfp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire acfp_pkg::tok_t   tok_in,
  input  wire logic             pop,
  output acfp_pkg::tok_t        tok_out,
  output acfp_pkg::q_stat_t     q_stat
);
  import acfp_pkg::*;

  tok_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= 2'(count + 2'd1);
        2'b01:   count <= 2'(count - 2'd1);
        default: count <= count;
      endcase
    end
    if (push) entries[wr_ptr] <= tok_in;
  end

  assign tok_out      = entries[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.valid = (count != 2'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/acfp_back.sv =====
// back end: parser state machine and result register
// depends on acfp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module acfp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire acfp_pkg::q_stat_t q_stat,
  input  wire acfp_pkg::tok_t tok,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          kind,
  output logic [31:0]         frame_id,
  output logic                is_extended,
  output logic                is_remote,
  output logic [3:0]          byte_count,
  output logic [63:0]         payload_out,
  output logic [7:0]          command_out,
  output logic [1:0]          status
);
  import acfp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ID, PH_DLC, PH_DATA, PH_CMD, PH_LEN, PH_CDATA
  } phase_t;

  phase_t             phase, phase_next;
  logic [DIGIT_W-1:0] digits_left, digits_left_next;
  logic [2:0]         byte_index, byte_index_next;
  logic               serial_flag, serial_flag_next;
  logic [31:0]        id_acc, id_acc_next;
  logic               ext_flag, ext_flag_next;
  logic               remote_flag, remote_flag_next;
  logic [LEN_W-1:0]   length_reg, length_reg_next;
  logic [63:0]        payload_reg, payload_reg_next;
  logic [7:0]         command_reg, command_reg_next;
  logic               emit_frame, emit_cmd;
  logic [5:0]         shift;
  status_t            st;

  // a token is consumed only when the result register can take a result
  assign pop = q_stat.valid && (!out_valid || out_ready);

  always_comb begin
    phase_next       = phase;
    digits_left_next = digits_left;
    byte_index_next  = byte_index;
    serial_flag_next = serial_flag;
    id_acc_next      = id_acc;
    ext_flag_next    = ext_flag;
    remote_flag_next = remote_flag;
    length_reg_next  = length_reg;
    payload_reg_next = payload_reg;
    command_reg_next = command_reg;
    emit_frame       = 1'b0;
    emit_cmd         = 1'b0;
    shift            = {byte_index, !digits_left[0], 2'b00};
    if (pop) begin
      case (phase)
        PH_IDLE: begin
          byte_index_next = '0;
          if (tok.frame_start) begin
            ext_flag_next    = tok.ext;
            remote_flag_next = tok.remote;
            digits_left_next = tok.ext ? DIGIT_W'(8) : DIGIT_W'(3);
            id_acc_next      = '0;
            payload_reg_next = '0;
            length_reg_next  = '0;
            serial_flag_next = 1'b0;
            phase_next       = PH_ID;
          end else if (tok.cmd_start) begin
            serial_flag_next = tok.serial;
            digits_left_next = DIGIT_W'(2);
            command_reg_next = '0;
            length_reg_next  = '0;
            payload_reg_next = '0;
            phase_next       = PH_CMD;
          end
        end
        PH_ID: begin
          if (!tok.is_hex) begin
            phase_next = PH_IDLE;
          end else begin
            id_acc_next      = {id_acc[27:0], tok.nib};
            digits_left_next = DIGIT_W'(digits_left - 1'b1);
            if (digits_left == DIGIT_W'(1)) phase_next = PH_DLC;
          end
        end
        PH_DLC: begin
          if (!tok.dlc_ok) begin
            phase_next = PH_IDLE;
          end else begin
            length_reg_next  = LEN_W'(tok.nib);
            byte_index_next  = '0;
            digits_left_next = DIGIT_W'({tok.nib, 1'b0});
            if (tok.nib == 4'd0) begin
              emit_frame = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA, PH_CDATA: begin
          if (!tok.is_hex) begin
            phase_next = PH_IDLE;
          end else begin
            payload_reg_next = payload_reg | (64'(tok.nib) << shift);
            digits_left_next = DIGIT_W'(digits_left - 1'b1);
            if (digits_left == DIGIT_W'(1)) begin
              emit_frame = (phase == PH_DATA);
              emit_cmd   = (phase == PH_CDATA);
              phase_next = PH_IDLE;
            end else if (!digits_left_next[0]) begin
              byte_index_next = 3'(byte_index + 1'b1);
            end
          end
        end
        PH_CMD: begin
          if (!tok.is_hex) begin
            phase_next = PH_IDLE;
          end else begin
            command_reg_next = {command_reg[3:0], tok.nib};
            digits_left_next = DIGIT_W'(digits_left - 1'b1);
            if (digits_left == DIGIT_W'(1)) begin
              digits_left_next = DIGIT_W'(2);
              phase_next       = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (!tok.is_hex) begin
            phase_next = PH_IDLE;
          end else begin
            length_reg_next  = {length_reg[3:0], tok.nib};
            digits_left_next = DIGIT_W'(digits_left - 1'b1);
            if (digits_left == DIGIT_W'(1)) begin
              if (length_reg_next > LEN_W'(MAX_CMD_BYTES)) begin
                phase_next = PH_IDLE;
              end else begin
                byte_index_next  = '0;
                digits_left_next = DIGIT_W'({length_reg_next[3:0], 1'b0});
                if (length_reg_next == '0) begin
                  emit_cmd   = 1'b1;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next = PH_CDATA;
                end
              end
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // serial command check on the final length and command byte
  always_comb begin
    st = ST_OK;
    if (serial_flag_next) begin
      if (length_reg_next > LEN_W'(MAX_CMD_BYTES)) begin
        st = ST_TOO_LONG;
      end else if (command_reg_next == '0 && length_reg_next > LEN_W'(BAUD_MAX_LEN)) begin
        st = ST_BAD_BAUD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digits_left <= '0;
      byte_index  <= '0;
      serial_flag <= 1'b0;
      id_acc      <= '0;
      ext_flag    <= 1'b0;
      remote_flag <= 1'b0;
      length_reg  <= '0;
      payload_reg <= '0;
      command_reg <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      digits_left <= digits_left_next;
      byte_index  <= byte_index_next;
      serial_flag <= serial_flag_next;
      id_acc      <= id_acc_next;
      ext_flag    <= ext_flag_next;
      remote_flag <= remote_flag_next;
      length_reg  <= length_reg_next;
      payload_reg <= payload_reg_next;
      command_reg <= command_reg_next;
      if (emit_frame || emit_cmd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (emit_frame) begin
      kind        <= KIND_FRAME;
      frame_id    <= id_acc_next;
      is_extended <= ext_flag_next;
      is_remote   <= remote_flag_next;
      byte_count  <= length_reg_next[3:0];
      payload_out <= payload_reg_next;
      command_out <= '0;
      status      <= ST_OK;
    end else if (emit_cmd) begin
      kind        <= serial_flag_next ? KIND_SERIAL : KIND_DEVICE;
      frame_id    <= '0;
      is_extended <= 1'b0;
      is_remote   <= 1'b0;
      byte_count  <= length_reg_next[3:0];
      payload_out <= payload_reg_next;
      command_out <= command_reg_next;
      status      <= st;
    end
  end

  `ASSERT_IMPLIES(a_digits_live, (phase == PH_ID || phase == PH_DATA || phase == PH_CDATA || phase == PH_CMD || phase == PH_LEN), (digits_left != '0), "field phase with no digits left")
  `ASSERT_IMPLIES(a_cdata_len, (phase == PH_CDATA), (length_reg <= LEN_W'(MAX_CMD_BYTES) && digits_left <= {length_reg[3:0], 1'b0}), "command data beyond capacity")
  `ASSERT_IMPLIES(a_no_emit_on_stall, (out_valid && !out_ready), (!emit_frame && !emit_cmd), "result produced while output stalled")
  `ASSERT_NEXT(a_cmd_to_len, (pop && phase == PH_CMD && tok.is_hex && digits_left == DIGIT_W'(1)), (phase == PH_LEN && digits_left == DIGIT_W'(2)), "command byte did not advance to length")

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_can_frame_parser.sv =====
// Text CAN protocol parser, one ASCII character per input transaction.
// Input channel: in_valid/in_ready with char_in. Output channel: out_valid/out_ready
// with kind, frame_id, is_extended, is_remote, byte_count, payload_out,
// command_out and status, one transaction per completed frame or command.
// Characters are classified in the front end, pass through a two-entry token
// queue, and are parsed by a state machine in the back end that writes a
// single result register.
// Throughput: one character per cycle, sustained while the receiver keeps up.
// With the queue empty, the character that completes a result passes through the queue
// register and then the result register before the result shows on the output.
// While a result waits on a stalled receiver the parser consumes nothing; the
// queue takes up to two more characters and in_ready drops once it is full.
// Reset (rst, synchronous, active high) empties the queue, returns the parser
// to idle with all accumulators cleared and drops out_valid.
// Depends on acfp_pkg, acfp_front, acfp_queue and acfp_back.
`default_nettype none

module ascii_can_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      frame_id,
  output logic             is_extended,
  output logic             is_remote,
  output logic [3:0]       byte_count,
  output logic [63:0]      payload_out,
  output logic [7:0]       command_out,
  output logic [1:0]       status
);
  import acfp_pkg::*;

  tok_t    tok_in, tok_out;
  q_stat_t q_stat;
  logic    push, pop;

  acfp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (char_in),
    .q_stat   (q_stat),
    .push     (push),
    .tok      (tok_in)
  );

  acfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .tok_in  (tok_in),
    .pop     (pop),
    .tok_out (tok_out),
    .q_stat  (q_stat)
  );

  acfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .tok         (tok_out),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .frame_id    (frame_id),
    .is_extended (is_extended),
    .is_remote   (is_remote),
    .byte_count  (byte_count),
    .payload_out (payload_out),
    .command_out (command_out),
    .status      (status)
  );

endmodule

`default_nettype wire
